FILE: sv/pfc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the pump and fan cooling controller.
// No dependencies; every other file of the block imports this package.
package pfc_pkg;

	localparam int TEMP_W    = 12;
	localparam int MS_W      = 10;
	localparam int KICK_W    = 14;
	localparam int DUTY_W    = 10;
	localparam int REG_IDX_W = 3;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;

	localparam logic [DUTY_W-1:0] FULL_DUTY   = 10'd1000;
	localparam logic [KICK_W-1:0] ELAPSED_MAX = 14'h3FFF;

	localparam logic [1:0] MODE_HV  = 2'd1;
	localparam logic [1:0] MODE_RUN = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_LATCH_ON   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LATCH_OFF  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HOT_ON     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HOT_OFF    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KICK_TIME  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FAN_NORMAL = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_FAN_HOT    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_PUMP_NORM  = 3'd7;

	localparam logic signed [TEMP_W-1:0] RST_LATCH_ON  = 12'sd500;
	localparam logic signed [TEMP_W-1:0] RST_LATCH_OFF = 12'sd450;
	localparam logic signed [TEMP_W-1:0] RST_HOT_ON    = 12'sd600;
	localparam logic signed [TEMP_W-1:0] RST_HOT_OFF   = 12'sd550;
	localparam logic [KICK_W-1:0]        RST_KICK_TIME = 14'd500;
	localparam logic [DUTY_W-1:0]        RST_FAN_NORM  = 10'd800;
	localparam logic [DUTY_W-1:0]        RST_FAN_HOT   = 10'd1000;
	localparam logic [DUTY_W-1:0]        RST_PUMP_NORM = 10'd1000;

	typedef struct packed {
		logic signed [TEMP_W-1:0] motor_temp;
		logic [MS_W-1:0]          elapsed_ms;
		logic [1:0]               vehicle_mode;
		logic                     pump_test_request;
		logic                     fan_test_request;
		logic                     pump_fault;
		logic                     fan_fault;
	} in_t;

	typedef struct packed {
		logic [DUTY_W-1:0] pump_duty_out;
		logic [DUTY_W-1:0] fan_duty_out;
		logic              pump_test_active;
		logic              fan_test_active;
		logic              cooling_latched_out;
		logic              drivetrain_hot_out;
	} out_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] latch_on_temp;
		logic signed [TEMP_W-1:0] latch_off_temp;
		logic signed [TEMP_W-1:0] hot_on_temp;
		logic signed [TEMP_W-1:0] hot_off_temp;
		logic [KICK_W-1:0]        kick_time_ms;
		logic [DUTY_W-1:0]        fan_duty_normal;
		logic [DUTY_W-1:0]        fan_duty_hot;
		logic [DUTY_W-1:0]        pump_duty_normal;
	} cfg_t;

	typedef enum logic [2:0] {
		PH_STOPPED = 3'b001,
		PH_RUNNING = 3'b010,
		PH_EXPIRED = 3'b100
	} phase_t;

	// Clamp a duty register to full scale.
	function automatic logic [DUTY_W-1:0] cap_duty(input logic [DUTY_W-1:0] d);
		return (d > FULL_DUTY) ? FULL_DUTY : d;
	endfunction

endpackage

FILE: sv/pfc_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on pfc_pkg for register indexes, reset values and cfg_t.
module pfc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pfc_pkg::PADDR_W-1:0]  paddr,
	input  logic [pfc_pkg::PDATA_W-1:0]  pwdata,
	output logic [pfc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output pfc_pkg::cfg_t                cfg
);
	import pfc_pkg::*;

	cfg_t                  cfg_q;
	logic                  wr_en;
	logic [REG_IDX_W-1:0]  idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.latch_on_temp    <= RST_LATCH_ON;
			cfg_q.latch_off_temp   <= RST_LATCH_OFF;
			cfg_q.hot_on_temp      <= RST_HOT_ON;
			cfg_q.hot_off_temp     <= RST_HOT_OFF;
			cfg_q.kick_time_ms     <= RST_KICK_TIME;
			cfg_q.fan_duty_normal  <= RST_FAN_NORM;
			cfg_q.fan_duty_hot     <= RST_FAN_HOT;
			cfg_q.pump_duty_normal <= RST_PUMP_NORM;
		end else if (wr_en) begin
			unique case (idx)
				REG_LATCH_ON:   cfg_q.latch_on_temp    <= $signed(pwdata[TEMP_W-1:0]);
				REG_LATCH_OFF:  cfg_q.latch_off_temp   <= $signed(pwdata[TEMP_W-1:0]);
				REG_HOT_ON:     cfg_q.hot_on_temp      <= $signed(pwdata[TEMP_W-1:0]);
				REG_HOT_OFF:    cfg_q.hot_off_temp     <= $signed(pwdata[TEMP_W-1:0]);
				REG_KICK_TIME:  cfg_q.kick_time_ms     <= pwdata[KICK_W-1:0];
				REG_FAN_NORMAL: cfg_q.fan_duty_normal  <= pwdata[DUTY_W-1:0];
				REG_FAN_HOT:    cfg_q.fan_duty_hot     <= pwdata[DUTY_W-1:0];
				REG_PUMP_NORM:  cfg_q.pump_duty_normal <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_LATCH_ON:   prdata = PDATA_W'(unsigned'(cfg_q.latch_on_temp));
			REG_LATCH_OFF:  prdata = PDATA_W'(unsigned'(cfg_q.latch_off_temp));
			REG_HOT_ON:     prdata = PDATA_W'(unsigned'(cfg_q.hot_on_temp));
			REG_HOT_OFF:    prdata = PDATA_W'(unsigned'(cfg_q.hot_off_temp));
			REG_KICK_TIME:  prdata = PDATA_W'(cfg_q.kick_time_ms);
			REG_FAN_NORMAL: prdata = PDATA_W'(cfg_q.fan_duty_normal);
			REG_FAN_HOT:    prdata = PDATA_W'(cfg_q.fan_duty_hot);
			REG_PUMP_NORM:  prdata = PDATA_W'(cfg_q.pump_duty_normal);
			default:        prdata = '0;
		endcase
	end

endmodule

FILE: sv/pfc_kick.sv
`timescale 1ns / 1ps
// Kick timer of one channel: phase and elapsed count, full-duty boost.
// Depends on pfc_pkg for phase_t and the duty and timer constants.
module pfc_kick (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic [pfc_pkg::MS_W-1:0]    ms,
	input  logic [pfc_pkg::KICK_W-1:0]  kick_time,
	input  logic [pfc_pkg::DUTY_W-1:0]  duty_req,
	output logic [pfc_pkg::DUTY_W-1:0]  duty
);
	import pfc_pkg::*;

	phase_t             phase_q, ph_adv, ph_nxt;
	logic [KICK_W-1:0]  elapsed_q, el_adv, el_nxt;
	logic [KICK_W:0]    sum;
	logic               expired;

	always_comb begin
		// Advance a running timer by this transfer's elapsed time.
		ph_adv = phase_q;
		el_adv = elapsed_q;
		sum    = {1'b0, elapsed_q} + (KICK_W+1)'(ms);
		if (phase_q == PH_RUNNING) begin
			el_adv = sum[KICK_W] ? ELAPSED_MAX : sum[KICK_W-1:0];
			if (el_adv >= kick_time) begin
				ph_adv = PH_EXPIRED;
			end
		end

		expired = (ph_adv != PH_STOPPED) && (ph_adv != PH_RUNNING);
		ph_nxt  = ph_adv;
		el_nxt  = el_adv;
		duty    = duty_req;
		if (duty_req != '0 && !expired) begin
			if (ph_adv != PH_RUNNING) begin
				ph_nxt = PH_RUNNING;
				el_nxt = '0;
			end
			duty = FULL_DUTY;
		end else if (duty_req == '0) begin
			ph_nxt = PH_STOPPED;
			el_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STOPPED;
			elapsed_q <= '0;
		end else if (upd) begin
			phase_q   <= ph_nxt;
			elapsed_q <= el_nxt;
		end
	end

endmodule

FILE: sv/pfc_ctrl.sv
`timescale 1ns / 1ps
// Per-tick control: hysteresis flags, test toggles, enables and duty selection.
// Depends on pfc_pkg and instantiates pfc_kick for pump and fan.
module pfc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           upd,
	input  pfc_pkg::in_t   item,
	input  pfc_pkg::cfg_t  cfg,
	output pfc_pkg::out_t  result
);
	import pfc_pkg::*;

	logic               cooling_q, hot_q, pump_test_q, fan_test_q;
	logic               prev_pump_req_q, prev_fan_req_q;
	logic               cooling_n, hot_n, pump_test_n, fan_test_n;
	logic               en_pump, en_fan;
	logic [DUTY_W-1:0]  sel_pump, sel_fan, req_pump, req_fan, duty_pump, duty_fan;

	always_comb begin
		cooling_n = cooling_q ? (item.motor_temp > cfg.latch_off_temp)
		                      : (item.motor_temp > cfg.latch_on_temp);

		pump_test_n = pump_test_q ^ (!prev_pump_req_q && item.pump_test_request);
		fan_test_n  = fan_test_q ^ (!prev_fan_req_q && item.fan_test_request);
		if (item.pump_fault) pump_test_n = 1'b0;
		if (item.fan_fault)  fan_test_n  = 1'b0;

		// Clear test runs after set test, so clear wins on overlap.
		hot_n = hot_q;
		if (item.motor_temp > cfg.hot_on_temp)  hot_n = 1'b1;
		if (item.motor_temp < cfg.hot_off_temp) hot_n = 1'b0;

		sel_fan  = fan_test_n ? FULL_DUTY
		         : cap_duty(hot_n ? cfg.fan_duty_hot : cfg.fan_duty_normal);
		sel_pump = pump_test_n ? FULL_DUTY : cap_duty(cfg.pump_duty_normal);

		en_pump = (item.vehicle_mode == MODE_HV || item.vehicle_mode == MODE_RUN
		           || pump_test_n || cooling_n) && !item.pump_fault;
		en_fan  = (item.vehicle_mode == MODE_RUN || fan_test_n || cooling_n)
		          && !item.fan_fault;

		req_pump = en_pump ? sel_pump : '0;
		req_fan  = en_fan ? sel_fan : '0;
	end

	pfc_kick u_pump_kick (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.ms        (item.elapsed_ms),
		.kick_time (cfg.kick_time_ms),
		.duty_req  (req_pump),
		.duty      (duty_pump)
	);

	pfc_kick u_fan_kick (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.ms        (item.elapsed_ms),
		.kick_time (cfg.kick_time_ms),
		.duty_req  (req_fan),
		.duty      (duty_fan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooling_q       <= 1'b0;
			hot_q           <= 1'b0;
			pump_test_q     <= 1'b0;
			fan_test_q      <= 1'b0;
			prev_pump_req_q <= 1'b0;
			prev_fan_req_q  <= 1'b0;
		end else if (upd) begin
			cooling_q       <= cooling_n;
			hot_q           <= hot_n;
			pump_test_q     <= pump_test_n;
			fan_test_q      <= fan_test_n;
			prev_pump_req_q <= item.pump_test_request;
			prev_fan_req_q  <= item.fan_test_request;
		end
	end

	assign result.pump_duty_out       = duty_pump;
	assign result.fan_duty_out        = duty_fan;
	assign result.pump_test_active    = pump_test_n;
	assign result.fan_test_active     = fan_test_n;
	assign result.cooling_latched_out = cooling_n;
	assign result.drivetrain_hot_out  = hot_n;

endmodule

FILE: sv/pump_fan_cooling_controller.sv
`timescale 1ns / 1ps
// Pump and fan cooling controller. Each input transfer is one periodic control
// tick (motor temperature, elapsed ms, vehicle mode, test requests, driver
// faults) and yields exactly one result transfer with pump and fan duty in
// per-mille, the test-mode states and the two hysteresis flags. The block
// takes one tick per clock cycle while the result side does not stall; each
// tick passes through the input register, then the result register. The
// flag, test-mode and kick-timer state is updated as each tick moves into
// the result register. A held result blocks the next tick from entering the
// input register only while that register is full. Configuration registers
// (APB, byte address 4*index) are to be written by the user only while the
// block is idle; the block does not enforce this. Reads return the register
// bits zero-extended. Depends on pfc_pkg, pfc_cfg_regs, pfc_ctrl and pfc_kick.
module pump_fan_cooling_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	// Tick input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  pfc_pkg::in_t                 in_data,
	// Result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output pfc_pkg::out_t                out_data,
	// Configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pfc_pkg::PADDR_W-1:0]  paddr,
	input  logic [pfc_pkg::PDATA_W-1:0]  pwdata,
	output logic [pfc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import pfc_pkg::*;

	cfg_t  cfg;
	in_t   item_s1;
	logic  valid_s1;
	out_t  res_q;
	logic  res_valid_q;
	out_t  result;
	logic  out_free;
	logic  advance;
	logic  in_xfer;

	pfc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The result register is free when empty or when its transfer completes now.
	assign out_free = !res_valid_q || !out_stall;
	// Move the tick from the input register into the result register, and
	// commit its state update at the same edge.
	assign advance  = valid_s1 && out_free;
	// Stall upstream only while the input register holds a tick that cannot move.
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload registers: load only, no reset.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_data;
		end
	end

	pfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Hold the result while the downstream stalls.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

endmodule

FILE: sv/pfc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the cooling controller, bound to the top level.
// Depends on pfc_pkg for the payload types and full-scale duty.
module pfc_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_stall,
	input  logic           out_valid,
	input  logic           out_stall,
	input  pfc_pkg::out_t  out_data
);
	import pfc_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// With the result register empty, the input side is never stalled.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	// Duties never exceed full scale.
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.pump_duty_out <= FULL_DUTY
		              && out_data.fan_duty_out <= FULL_DUTY)
		else $error("duty above full scale");

	// A channel in test mode drives full duty.
	a_test_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.pump_test_active || out_data.pump_duty_out == FULL_DUTY)
		              && (!out_data.fan_test_active || out_data.fan_duty_out == FULL_DUTY))
		else $error("test mode without full duty");

endmodule

bind pump_fan_cooling_controller pfc_checker u_pfc_checker (.*);
